@@ hdl/crcdf_pkg.sv @@
// Shared types, constants and the byte-wide CRC-32 update for the frame deframer.
`default_nettype none

package crcdf_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [15:0] CHUNK_MIN_LEN = 16'd32;
    localparam logic [15:0] PONG_MIN_LEN  = 16'd16;
    localparam logic [1:0]  MAGIC_LAST    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAGIC_WORD  = 2'd0;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd1;
    localparam logic [1:0] REG_CHUNK_TYPE  = 2'd2;
    localparam logic [1:0] REG_PONG_TYPE   = 2'd3;

    // Frame classification codes.
    localparam logic [1:0] KIND_IGNORED = 2'd0;
    localparam logic [1:0] KIND_CHUNK   = 2'd1;
    localparam logic [1:0] KIND_PONG    = 2'd2;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] max_payload;
        logic [7:0]  chunk_type;
        logic [7:0]  pong_type;
    } cfg_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        header_rejected;
        logic        frame_done;
        logic        crc_ok;
        logic [1:0]  frame_kind;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
    } result_t;

    // Reflected CRC-32 update over one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Magic byte expected at a given match position.
    function automatic logic [7:0] magic_byte(input logic [31:0] word,
                                              input logic [1:0]  pos);
        return word[{pos, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

@@ hdl/crcdf_cfg.sv @@
// Configuration register bank of the frame deframer.
`default_nettype none

module crcdf_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output crcdf_pkg::cfg_t     cfg
);
    import crcdf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.magic_word  <= 32'd0;
            cfg_reg.max_payload <= 16'd1024;
            cfg_reg.chunk_type  <= 8'd1;
            cfg_reg.pong_type   <= 8'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAGIC_WORD:  cfg_reg.magic_word  <= cfg_data;
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_data[15:0];
                REG_CHUNK_TYPE:  cfg_reg.chunk_type  <= cfg_data[7:0];
                REG_PONG_TYPE:   cfg_reg.pong_type   <= cfg_data[7:0];
                default:         cfg_reg.magic_word  <= cfg_reg.magic_word;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/crcdf_engine.sv @@
// Parse state machine and running CRC; computes one result per byte.
`default_nettype none

module crcdf_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          rx_byte,
    input  crcdf_pkg::cfg_t     cfg,
    output crcdf_pkg::result_t  result
);
    import crcdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LENLO,
        PH_LENHI,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [1:0]  magic_pos_reg, magic_pos_next;
    logic [31:0] crc_reg,       crc_next;
    logic [7:0]  type_reg,      type_next;
    logic [15:0] length_reg,    length_next;
    logic [15:0] count_reg,     count_next;
    logic [1:0]  chk_cnt_reg,   chk_cnt_next;
    logic [31:0] rx_crc_reg,    rx_crc_next;

    logic [15:0] new_length;
    result_t     res;

    always_comb begin
        phase_next     = phase_reg;
        magic_pos_next = magic_pos_reg;
        crc_next       = crc_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        chk_cnt_next   = chk_cnt_reg;
        rx_crc_next    = rx_crc_reg;
        new_length     = {rx_byte, length_reg[7:0]};
        res            = '0;

        unique case (phase_reg)
            PH_TYPE: begin
                type_next  = rx_byte;
                crc_next   = crc_byte(crc_reg, rx_byte);
                phase_next = PH_LENLO;
            end
            PH_LENLO: begin
                length_next = {8'd0, rx_byte};
                crc_next    = crc_byte(crc_reg, rx_byte);
                phase_next  = PH_LENHI;
            end
            PH_LENHI: begin
                length_next = new_length;
                crc_next    = crc_byte(crc_reg, rx_byte);
                if (new_length == 16'd0 || new_length > cfg.max_payload) begin
                    res.header_rejected = 1'b1;
                    phase_next          = PH_HUNT;
                end else begin
                    count_next = 16'd0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = rx_byte;
                res.payload_index = count_reg;
                count_next        = count_reg + 16'd1;
                crc_next          = crc_byte(crc_reg, rx_byte);
                if (count_next >= length_reg) begin
                    chk_cnt_next = 2'd0;
                    phase_next   = PH_CHECK;
                end
            end
            PH_CHECK: begin
                rx_crc_next  = {rx_byte, rx_crc_reg[31:8]};
                chk_cnt_next = chk_cnt_reg + 2'd1;
                if (chk_cnt_next == 2'd0) begin
                    res.frame_done = 1'b1;
                    res.crc_ok     = (rx_crc_next == ~crc_reg);
                    if (res.crc_ok) begin
                        if (type_reg == cfg.chunk_type && length_reg >= CHUNK_MIN_LEN) begin
                            res.frame_kind = KIND_CHUNK;
                        end else if (type_reg == cfg.pong_type
                                     && length_reg >= PONG_MIN_LEN) begin
                            res.frame_kind = KIND_PONG;
                        end else begin
                            res.frame_kind = KIND_IGNORED;
                        end
                    end
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                // Magic hunt; a mismatch that equals the first magic byte restarts
                // the match at position one.
                phase_next = PH_HUNT;
                if (rx_byte == magic_byte(cfg.magic_word, magic_pos_reg)) begin
                    crc_next = crc_byte((magic_pos_reg == 2'd0) ? CRC_INIT : crc_reg,
                                        rx_byte);
                    magic_pos_next = magic_pos_reg + 2'd1;
                    if (magic_pos_reg == MAGIC_LAST) begin
                        phase_next = PH_TYPE;
                    end
                end else if (rx_byte == magic_byte(cfg.magic_word, 2'd0)) begin
                    magic_pos_next = 2'd1;
                    crc_next       = crc_byte(CRC_INIT, rx_byte);
                end else begin
                    magic_pos_next = 2'd0;
                end
            end
        endcase

        res.frame_type   = type_next;
        res.frame_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= PH_HUNT;
            magic_pos_reg <= 2'd0;
            crc_reg       <= CRC_INIT;
            type_reg      <= 8'd0;
            length_reg    <= 16'd0;
            count_reg     <= 16'd0;
            chk_cnt_reg   <= 2'd0;
            rx_crc_reg    <= 32'd0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            magic_pos_reg <= magic_pos_next;
            crc_reg       <= crc_next;
            type_reg      <= type_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            chk_cnt_reg   <= chk_cnt_next;
            rx_crc_reg    <= rx_crc_next;
        end
    end

    assign result = res;

    a_reject_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.header_rejected |=> phase_reg == PH_HUNT)
        else $error("rejected header did not return to magic hunt");

    a_done_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.frame_done |=> phase_reg == PH_HUNT && magic_pos_reg == 2'd0)
        else $error("finished frame did not return to magic hunt");

    a_kind_needs_crc: assert property (@(posedge clk) disable iff (!rst_n)
        res.frame_kind != KIND_IGNORED |-> res.frame_done && res.crc_ok)
        else $error("frame classified without a matching CRC");

    a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.payload_valid |-> res.payload_index < length_reg)
        else $error("payload index beyond header length");

endmodule

`default_nettype wire

@@ hdl/crc32_serial_frame_deframer_core.sv @@
// Top level of the magic-word frame deframer with CRC-32 check.
// A taken byte waits in the input byte register, and its result is written to the
// result register when the byte is processed. Throughput: one byte per cycle while
// the output is not stalled; the byte-wide CRC and parse logic are combinational.
// Reset (rst_n low, asynchronous): parser hunts for the magic word, CRC is all ones,
// registers return to magic 0, max payload 1024, chunk type 1, pong type 2.
`default_nettype none

module crc32_serial_frame_deframer_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic        header_rejected,
    output logic        frame_done,
    output logic        crc_ok,
    output logic [1:0]  frame_kind,
    output logic [7:0]  frame_type,
    output logic [15:0] frame_length,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import crcdf_pkg::*;

    // The two stages move together. Whenever the result register is empty or
    // its transaction completes, every stage advances by one, so a new byte
    // is taken while the previous result is being handed over.
    logic    advance;
    logic    fire;
    logic    in_valid_reg;
    logic [7:0] in_byte_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    cfg_t    cfg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    // The parser state moves only when the held byte is actually processed.
    assign fire     = advance && in_valid_reg;

    crcdf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crcdf_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg  <= in_valid;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers carry no reset; they are qualified by the valid bits.
    always_ff @(posedge clk) begin
        if (advance && in_valid) begin
            in_byte_reg <= rx_byte;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_valid   = out_reg.payload_valid;
    assign payload_byte    = out_reg.payload_byte;
    assign payload_index   = out_reg.payload_index;
    assign header_rejected = out_reg.header_rejected;
    assign frame_done      = out_reg.frame_done;
    assign crc_ok          = out_reg.crc_ok;
    assign frame_kind      = out_reg.frame_kind;
    assign frame_type      = out_reg.frame_type;
    assign frame_length    = out_reg.frame_length;

    a_held_byte_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("processed byte produced no result");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(in_valid_reg) && out_valid_reg)
        else $error("pipeline moved while the output was stalled");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({payload_valid, header_rejected, frame_done}))
        else $error("result carries more than one frame event");

endmodule

`default_nettype wire

@@ dv/crc32_serial_frame_deframer_core_tb.sv @@
// Self-checking testbench for the magic-word frame deframer with CRC-32 check.
`default_nettype none

module crc32_serial_frame_deframer_core_tb;

    import crcdf_pkg::*;

    typedef enum logic [2:0] {
        SEEK_MAGIC,
        GET_TYPE,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_BODY,
        GET_CRC
    } parse_phase_e;

    // Reflected CRC-32 over one byte, one data bit at a time.
    function automatic logic [31:0] crc_bit_step(logic [31:0] acc, logic [7:0] data);
        logic [31:0] c;
        bit          fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // Predicts one result per received byte and checks the block's results in order.
    class frame_scoreboard;
        logic [31:0]  magic;
        logic [15:0]  max_len;
        logic [7:0]   chunk_id;
        logic [7:0]   pong_id;

        parse_phase_e phase;
        logic [1:0]   magic_pos;
        logic [31:0]  crc_acc;
        logic [7:0]   type_hold;
        logic [15:0]  len_hold;
        logic [15:0]  body_count;
        logic [1:0]   trailer_count;
        logic [31:0]  trailer_word;

        result_t      expected_q[$];

        int errors;
        int n_bytes;
        int n_payload;
        int n_reject;
        int n_done;
        int n_chunk;
        int n_pong;
        int n_ignored;
        int n_bad_crc;

        function new();
            magic         = 32'd0;
            max_len       = 16'd1024;
            chunk_id      = 8'd1;
            pong_id       = 8'd2;
            phase         = SEEK_MAGIC;
            magic_pos     = 2'd0;
            crc_acc       = CRC_INIT;
            type_hold     = 8'd0;
            len_hold      = 16'd0;
            body_count    = 16'd0;
            trailer_count = 2'd0;
            trailer_word  = 32'd0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_MAGIC_WORD:  magic    = data;
                REG_MAX_PAYLOAD: max_len  = data[15:0];
                REG_CHUNK_TYPE:  chunk_id = data[7:0];
                REG_PONG_TYPE:   pong_id  = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the parser by one accepted byte and queue the result it causes.
        function void note_byte(logic [7:0] b);
            result_t r;
            r = '0;
            n_bytes++;
            case (phase)
                GET_TYPE: begin
                    type_hold = b;
                    crc_acc   = crc_bit_step(crc_acc, b);
                    phase     = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    len_hold = {8'd0, b};
                    crc_acc  = crc_bit_step(crc_acc, b);
                    phase    = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    len_hold[15:8] = b;
                    crc_acc        = crc_bit_step(crc_acc, b);
                    if (len_hold == 16'd0 || len_hold > max_len) begin
                        r.header_rejected = 1'b1;
                        n_reject++;
                        phase = SEEK_MAGIC;
                    end else begin
                        body_count = 16'd0;
                        phase      = GET_BODY;
                    end
                end
                GET_BODY: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = body_count;
                    n_payload++;
                    body_count = body_count + 16'd1;
                    crc_acc    = crc_bit_step(crc_acc, b);
                    if (body_count >= len_hold) begin
                        trailer_count = 2'd0;
                        phase         = GET_CRC;
                    end
                end
                GET_CRC: begin
                    trailer_word  = {b, trailer_word[31:8]};
                    trailer_count = trailer_count + 2'd1;
                    if (trailer_count == 2'd0) begin
                        r.frame_done = 1'b1;
                        r.crc_ok     = (trailer_word == ~crc_acc);
                        r.frame_kind = KIND_IGNORED;
                        n_done++;
                        if (!r.crc_ok) begin
                            n_bad_crc++;
                        end else if (type_hold == chunk_id && len_hold >= CHUNK_MIN_LEN) begin
                            r.frame_kind = KIND_CHUNK;
                            n_chunk++;
                        end else if (type_hold == pong_id && len_hold >= PONG_MIN_LEN) begin
                            r.frame_kind = KIND_PONG;
                            n_pong++;
                        end else begin
                            n_ignored++;
                        end
                        phase = SEEK_MAGIC;
                    end
                end
                default: begin
                    phase = SEEK_MAGIC;
                    if (b == magic[magic_pos * 8 +: 8]) begin
                        crc_acc = crc_bit_step((magic_pos == 2'd0) ? CRC_INIT : crc_acc, b);
                        if (magic_pos == MAGIC_LAST) begin
                            magic_pos = 2'd0;
                            phase     = GET_TYPE;
                        end else begin
                            magic_pos = magic_pos + 2'd1;
                        end
                    end else if (b == magic[7:0]) begin
                        magic_pos = 2'd1;
                        crc_acc   = crc_bit_step(CRC_INIT, b);
                    end else begin
                        magic_pos = 2'd0;
                    end
                end
            endcase
            r.frame_type   = type_hold;
            r.frame_length = len_hold;
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no expectation waiting, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            cmp_field("payload_valid",   32'(want.payload_valid),   32'(got.payload_valid));
            cmp_field("payload_byte",    32'(want.payload_byte),    32'(got.payload_byte));
            cmp_field("payload_index",   32'(want.payload_index),   32'(got.payload_index));
            cmp_field("header_rejected", 32'(want.header_rejected),
                      32'(got.header_rejected));
            cmp_field("frame_done",      32'(want.frame_done),      32'(got.frame_done));
            cmp_field("crc_ok",          32'(want.crc_ok),          32'(got.crc_ok));
            cmp_field("frame_kind",      32'(want.frame_kind),      32'(got.frame_kind));
            cmp_field("frame_type",      32'(want.frame_type),      32'(got.frame_type));
            cmp_field("frame_length",    32'(want.frame_length),    32'(got.frame_length));
        endfunction
    endclass

    // The watchdog ends the run after this many cycles without any transaction.
    localparam int STALL_LIMIT = 1000;
    // Length of the long receiver hold-off that fills the block up.
    localparam int LONG_HOLD   = 80;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        header_rejected;
    logic        frame_done;
    logic        crc_ok;
    logic [1:0]  frame_kind;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    frame_scoreboard sb = new();

    // Idle controls for the stimulus and receiver threads, and the watchdog's quiet count.
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_req;
    int rx_left;
    int quiet_cycles;

    crc32_serial_frame_deframer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_valid   (payload_valid),
        .payload_byte    (payload_byte),
        .payload_index   (payload_index),
        .header_rejected (header_rejected),
        .frame_done      (frame_done),
        .crc_ok          (crc_ok),
        .frame_kind      (frame_kind),
        .frame_type      (frame_type),
        .frame_length    (frame_length),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Leave the input idle for a number of cycles. While idle the byte lines carry
    // junk, which the block must ignore.
    task automatic tx_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
        end
    endtask

    // Offer one byte and hold it until the block takes the transaction. The byte is
    // handed to the predictor at the very edge where it is accepted.
    task automatic put_byte(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 9) == 0) begin
            tx_gap($urandom_range(1, 11));
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sb.note_byte(b);
    endtask

    // Stop offering input and wait until every expected result has been taken.
    // Each byte causes exactly one result, so an empty queue means the block is idle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Build a frame from the current register values and send it. A frame whose
    // header the block will reject is sent only up to the length bytes. A cut
    // frame stops at a random point, so the next bytes land mid-frame.
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                              input bit bad_crc, input bit cut);
        logic [7:0]  seq[$];
        logic [31:0] acc;
        int          n_send;
        for (int k = 0; k < 4; k++) begin
            seq.push_back(sb.magic[8 * k +: 8]);
        end
        seq.push_back(ftype);
        seq.push_back(flen[7:0]);
        seq.push_back(flen[15:8]);
        if (flen != 16'd0 && flen <= sb.max_len) begin
            repeat (flen)
            begin
                seq.push_back(8'($urandom));
            end
            acc = CRC_INIT;
            foreach (seq[k]) begin
                acc = crc_bit_step(acc, seq[k]);
            end
            acc = ~acc;
            if (bad_crc) begin
                acc = acc ^ (32'd1 << $urandom_range(0, 31));
            end
            for (int k = 0; k < 4; k++) begin
                seq.push_back(acc[8 * k +: 8]);
            end
        end
        n_send = cut ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int k = 0; k < n_send; k++) begin
            put_byte(seq[k]);
        end
    endtask

    // One random frame with some noise in front. Most frames are well formed, with
    // types and lengths chosen to hit the chunk and pong classes and the length
    // limits; a few carry a bad CRC or are cut short.
    task automatic send_random_frame();
        logic [7:0]  ft;
        logic [15:0] fl;
        int          sel;
        int          cap;
        repeat ($urandom_range(0, 2))
        begin
            put_byte(8'($urandom));
        end
        // A stray first magic byte in front of the real one forces a resync.
        if ($urandom_range(0, 4) == 0) begin
            put_byte(sb.magic[7:0]);
        end
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            ft = sb.chunk_id;
        end else if (sel < 8) begin
            ft = sb.pong_id;
        end else begin
            ft = 8'($urandom);
        end
        sel = $urandom_range(0, 11);
        case (sel)
            0: fl = 16'd0;
            1: fl = (sb.max_len == 16'hFFFF) ? 16'($urandom) : sb.max_len + 16'd1;
            2: fl = 16'($urandom);
            3: fl = (sb.max_len <= 16'd64) ? sb.max_len : 16'($urandom_range(16, 48));
            4: fl = 16'($urandom_range(30, 34));
            5: fl = 16'($urandom_range(14, 18));
            default: fl = 16'($urandom_range(1, 48));
        endcase
        // Keep accepted frames short so the run stays small.
        if (fl != 16'd0 && fl <= sb.max_len && fl > 16'd64) begin
            cap = (sb.max_len < 16'd64) ? int'(sb.max_len) : 64;
            fl  = 16'($urandom_range(1, cap));
        end
        send_frame(ft, fl, $urandom_range(0, 5) == 0, $urandom_range(0, 11) == 0);
    endtask

    // Register settings for each phase of the run. Every phase but phase 3 writes every
    // register, and the extremes of each range come up at least once.
    task automatic configure(input int p);
        logic [7:0] a;
        a = 8'($urandom);
        case (p)
            0: begin
                write_reg(REG_MAGIC_WORD, $urandom);
                write_reg(REG_MAX_PAYLOAD, 32'd1024);
                write_reg(REG_CHUNK_TYPE, 32'd1);
                write_reg(REG_PONG_TYPE, 32'd2);
            end
            1: begin
                write_reg(REG_MAGIC_WORD, 32'hFFFF_FFFF);
                write_reg(REG_MAX_PAYLOAD, 32'h0000_FFFF);
                write_reg(REG_CHUNK_TYPE, 32'h0000_00FF);
                write_reg(REG_PONG_TYPE, 32'd0);
            end
            2: begin
                // Chunk and pong share one type byte, so the chunk test must win.
                write_reg(REG_MAGIC_WORD, $urandom);
                write_reg(REG_MAX_PAYLOAD, 32'd40);
                write_reg(REG_CHUNK_TYPE, {24'd0, a});
                write_reg(REG_PONG_TYPE, {24'd0, a});
            end
            3: begin
                // With a zero limit every header is rejected.
                write_reg(REG_MAGIC_WORD, $urandom);
                write_reg(REG_MAX_PAYLOAD, 32'd0);
            end
            4: begin
                // A repeated first magic byte exercises the resync path.
                write_reg(REG_MAGIC_WORD, {8'($urandom), 8'($urandom), a, a});
                write_reg(REG_MAX_PAYLOAD, 32'd1);
                write_reg(REG_CHUNK_TYPE, 32'd0);
                write_reg(REG_PONG_TYPE, 32'h0000_00FF);
            end
            default: begin
                write_reg(REG_MAGIC_WORD, $urandom);
                write_reg(REG_MAX_PAYLOAD, $urandom_range(16, 64));
                write_reg(REG_CHUNK_TYPE, $urandom_range(0, 255));
                write_reg(REG_PONG_TYPE, $urandom_range(0, 255));
            end
        endcase
    endtask

    // Receiver: stalls the result channel in random bursts, or for one long
    // stretch when the stimulus thread asks for it. The long stretch is counted
    // here so the sender keeps offering bytes meanwhile.
    initial
    begin
        out_stall = 1'b0;
        rx_left   = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0) begin
                rx_left     = rx_hold_req;
                rx_hold_req = 0;
            end else if (rx_left == 0 && rx_idle_on && $urandom_range(0, 9) == 0) begin
                rx_left = $urandom_range(1, 11);
            end
            if (rx_left > 0) begin
                out_stall <= 1'b1;
                rx_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Result monitor: every accepted result transaction is checked against the
    // oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.payload_valid   = payload_valid;
            got.payload_byte    = payload_byte;
            got.payload_index   = payload_index;
            got.header_rejected = header_rejected;
            got.frame_done      = frame_done;
            got.crc_ok          = crc_ok;
            got.frame_kind      = frame_kind;
            got.frame_type      = frame_type;
            got.frame_length    = frame_length;
            sb.check_result(got);
        end
    end

    // Watchdog: counts cycles in which no transaction of any kind takes place.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("crc32_serial_frame_deframer_core_tb failed");
        $finish;
    end

    // Main stimulus thread.
    initial
    begin
        int start;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'd0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MAGIC_WORD;
        cfg_data    = 32'd0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings, where the magic word is all
        // zeros: a partial match broken by an all-ones byte, a zero-length header,
        // a one-byte frame and a header just over the limit.
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'hFF);
        send_frame(sb.pong_id, 16'd0, 1'b0, 1'b0);
        send_frame(sb.chunk_id, 16'd1, 1'b0, 1'b0);
        send_frame(8'hFF, 16'd1025, 1'b0, 1'b0);

        for (int p = 0; p < 6; p++) begin
            drain();
            configure(p);
            if (p == 5) begin
                // The last part of the run has no idling on either side.
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (p == 0) begin
                // Hold the results back while a long chunk streams in, so the
                // block fills up and stalls its input.
                tx_idle_on  = 1'b0;
                rx_hold_req = LONG_HOLD;
                send_frame(sb.chunk_id, 16'd40, 1'b0, 1'b0);
            end
            start = sb.n_bytes;
            while (sb.n_bytes - start < 45) begin
                if (p != 5) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                send_random_frame();
            end
        end

        drain();
        // Waiting on after the drain catches any result the block should not have produced.
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes over seven register settings: %0d payload bytes, %0d headers rejected.",
                 sb.n_bytes, sb.n_payload, sb.n_reject);
        $display("Closed %0d frames: %0d chunks, %0d pongs, %0d ignored, %0d with a bad CRC.",
                 sb.n_done, sb.n_chunk, sb.n_pong, sb.n_ignored, sb.n_bad_crc);
        if (sb.errors == 0) begin
            $display("crc32_serial_frame_deframer_core_tb passed");
        end else begin
            $display("crc32_serial_frame_deframer_core_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
